// File: rtl/rsd_pkg.sv
// Package for the running standard deviation block: widths, the queue
// word type and the back-end state encoding. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

  // Configuration of the datapath
  localparam int COUNT_BITS  = 16;
  localparam int SAMPLE_BITS = 16;

  // Port widths, fixed by the interface definition
  localparam int SAMPLE_W  = 16;
  localparam int STD_W     = 16;
  localparam int CNT_OUT_W = 16;

  // Derived widths
  localparam int SUM_W   = COUNT_BITS + SAMPLE_BITS;          // running sum, signed
  localparam int MAG_W   = COUNT_BITS + SAMPLE_BITS - 1;      // |sum|
  localparam int SQX_W   = 2 * SAMPLE_BITS - 1;               // one squared sample
  localparam int SQ_W    = COUNT_BITS + 2 * SAMPLE_BITS - 1;  // sum of squares
  localparam int SPLIT   = (SQ_W + 1) / 2;                    // n*S2 split point
  localparam int PROD_W  = COUNT_BITS + SPLIT;                // partial product
  localparam int DIFF_W  = COUNT_BITS + SQ_W;                 // n*S2 - S1^2
  localparam int ROOT_W  = (DIFF_W + 1) / 2;                  // isqrt result
  localparam int RAD_W   = 2 * ROOT_W;                        // padded radicand
  localparam int REM_W   = ROOT_W + 3;                        // root remainder
  localparam int QUO_W   = SAMPLE_BITS;                       // std dev quotient
  localparam int STEP_W  = $clog2(ROOT_W);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [STD_W-1:0]      STD_MAX   = STD_W'(1) << (SAMPLE_BITS - 1);

  // Front-to-back queue
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [COUNT_BITS-1:0]   count;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
    logic                    sat;
  } rsd_stats_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL_A,
    B_MUL_B,
    B_ADD,
    B_SUB,
    B_SQRT,
    B_PREP,
    B_DIV,
    B_DONE
  } rsd_back_state_t;

endpackage

`default_nettype wire

// File: rtl/rsd_if.sv
// Valid/ready channels for sample words in and result words out.
// Depends on rsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rsd_in_if;
  import rsd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rsd_out_if;
  import rsd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STD_W-1:0]     std_dev;
  logic [CNT_OUT_W-1:0] sample_count;
  logic                 saturated;

  modport source (output valid, output std_dev, output sample_count, output saturated,
                  input ready);
  modport sink   (input valid, input std_dev, input sample_count, input saturated,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/rsd_front.sv
// Front end: takes sample words, keeps count, sum and sum of squares,
// and pushes a snapshot per word to the queue. Depends on rsd_pkg, rsd_if.
`timescale 1ns / 1ps
`default_nettype none

module rsd_front (
  input  wire logic        clk,
  input  wire logic        rst,
  rsd_in_if.sink           samples,
  output logic             push_valid,
  input  wire logic        push_ready,
  output rsd_pkg::rsd_stats_t push_data
);
  import rsd_pkg::*;

  logic [COUNT_BITS-1:0]         count, count_next;
  logic signed [SUM_W-1:0]       sum, sum_next;
  logic [SQ_W-1:0]               sumsq, sumsq_next;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [2*SAMPLE_BITS-1:0] x_prod;
  logic [SQX_W-1:0]              x_sq;
  logic                          full;
  logic                          take;

  // only the low SAMPLE_BITS are meaningful
  assign x      = samples.sample[SAMPLE_BITS-1:0];
  assign x_prod = (2*SAMPLE_BITS)'(x) * (2*SAMPLE_BITS)'(x);
  assign x_sq   = x_prod[SQX_W-1:0];
  assign full   = (count == COUNT_MAX);

  always_comb begin
    if (full) begin
      count_next = count;
      sum_next   = sum;
      sumsq_next = sumsq;
    end else begin
      count_next = count + COUNT_BITS'(1);
      sum_next   = sum + {{(SUM_W-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
      sumsq_next = sumsq + SQ_W'(x_sq);
    end
  end

  assign samples.ready   = push_ready;
  assign push_valid      = samples.valid;
  assign take            = samples.valid && push_ready;
  assign push_data.count = count_next;
  assign push_data.sum   = sum_next;
  assign push_data.sumsq = sumsq_next;
  assign push_data.sat   = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
      sumsq <= '0;
    end else if (take) begin
      count <= count_next;
      sum   <= sum_next;
      sumsq <= sumsq_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rsd_fifo.sv
// Short queue of statistics snapshots between front and back end.
// Depends on rsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsd_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire rsd_pkg::rsd_stats_t push_data,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output rsd_pkg::rsd_stats_t      pop_data
);
  import rsd_pkg::*;

  rsd_stats_t         mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (FIFO_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/rsd_back.sv
// Back end: n*S2 - S1^2, bit-serial integer square root, restoring
// divide by n, and the output register. Depends on rsd_pkg, rsd_if.
`timescale 1ns / 1ps
`default_nettype none

module rsd_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                pop_valid,
  output logic                     pop_ready,
  input  wire rsd_pkg::rsd_stats_t pop_data,
  rsd_out_if.source                results
);
  import rsd_pkg::*;

  rsd_back_state_t state, state_next;

  logic [COUNT_BITS-1:0] n;
  logic [SQ_W-1:0]       s2;
  logic [MAG_W-1:0]      mag;
  logic                  sat;
  logic [PROD_W-1:0]     prod;
  logic [2*MAG_W-1:0]    sq;
  logic [DIFF_W-1:0]     acc;
  logic [RAD_W-1:0]      rad;
  logic [ROOT_W-1:0]     root;
  logic [REM_W-1:0]      srem;
  logic [COUNT_BITS-1:0] drem;
  logic [QUO_W-1:0]      quo;
  logic [STEP_W-1:0]     step;

  logic                  res_valid;
  logic [STD_W-1:0]      res_std;
  logic [CNT_OUT_W-1:0]  res_count;
  logic                  res_sat;

  logic [SUM_W-1:0]      sum_abs;
  logic [REM_W-1:0]      srem_sh;
  logic [REM_W-1:0]      s_trial;
  logic                  s_ge;
  logic [COUNT_BITS:0]   d_trial;
  logic [COUNT_BITS:0]   d_diff;
  logic                  d_ge;
  logic                  load_out;

  assign sum_abs = pop_data.sum[SUM_W-1] ? (~pop_data.sum + SUM_W'(1)) : pop_data.sum;

  // one root digit per cycle
  assign srem_sh = {srem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign s_trial = REM_W'({root, 2'b01});
  assign s_ge    = (srem_sh >= s_trial);

  // one quotient bit per cycle; quo holds the dividend bits still to come
  assign d_trial = {drem, quo[QUO_W-1]};
  assign d_diff  = d_trial - {1'b0, n};
  assign d_ge    = (d_trial >= {1'b0, n});

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    load_out   = 1'b0;
    case (state)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = (pop_data.count <= COUNT_BITS'(1)) ? B_DONE : B_MUL_A;
        end
      end
      B_MUL_A: state_next = B_MUL_B;
      B_MUL_B: state_next = B_ADD;
      B_ADD:   state_next = B_SUB;
      B_SUB:   state_next = B_SQRT;
      B_SQRT: begin
        if (step == '0) begin
          state_next = B_PREP;
        end
      end
      B_PREP:  state_next = B_DIV;
      B_DIV: begin
        if (step == '0) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (!res_valid || results.ready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        n   <= pop_data.count;
        s2  <= pop_data.sumsq;
        mag <= sum_abs[MAG_W-1:0];
        sat <= pop_data.sat;
        quo <= '0;
      end
      B_MUL_A: begin
        prod <= PROD_W'(n) * PROD_W'(s2[SPLIT-1:0]);
        sq   <= (2*MAG_W)'(mag) * (2*MAG_W)'(mag);
      end
      B_MUL_B: begin
        acc  <= DIFF_W'(prod);
        prod <= PROD_W'(n) * PROD_W'(s2[SQ_W-1:SPLIT]);
      end
      B_ADD: begin
        acc <= acc + (DIFF_W'(prod) << SPLIT);
      end
      B_SUB: begin
        rad  <= RAD_W'(acc - DIFF_W'(sq));
        root <= '0;
        srem <= '0;
        step <= STEP_W'(ROOT_W - 1);
      end
      B_SQRT: begin
        rad  <= rad << 2;
        srem <= s_ge ? (srem_sh - s_trial) : srem_sh;
        root <= {root[ROOT_W-2:0], s_ge};
        step <= step - STEP_W'(1);
      end
      B_PREP: begin
        // root < n * 2^QUO_W, so the top part is already below n
        drem <= root[ROOT_W-1:QUO_W];
        quo  <= root[QUO_W-1:0];
        step <= STEP_W'(QUO_W - 1);
      end
      B_DIV: begin
        drem <= d_ge ? d_diff[COUNT_BITS-1:0] : d_trial[COUNT_BITS-1:0];
        quo  <= {quo[QUO_W-2:0], d_ge};
        step <= step - STEP_W'(1);
      end
      B_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_std   <= STD_W'(quo);
      res_count <= CNT_OUT_W'(n);
      res_sat   <= sat;
    end
  end

  assign results.valid        = res_valid;
  assign results.std_dev      = res_std;
  assign results.sample_count = res_count;
  assign results.saturated    = res_sat;

endmodule

`default_nettype wire

// File: rtl/running_standard_deviation.sv
// Running population standard deviation of signed Q8.8 samples, result Q8.8.
// The back end handles one word at a time, through a 32-step square root and a
//   16-step divide; when the count is 0 or 1 it skips both and reports zero.
// A finished result waits in the back end until the output register is free.
// Reset (rst, synchronous): count, sum and sum of squares cleared, queue emptied.
// Depends on rsd_pkg, rsd_if, rsd_front, rsd_fifo, rsd_back.
`timescale 1ns / 1ps
`default_nettype none

module running_standard_deviation (
  input  wire logic clk,
  input  wire logic rst,
  rsd_in_if.sink    samples,
  rsd_out_if.source results
);
  import rsd_pkg::*;

  // Front end and back end are decoupled by a two-word queue: the front
  // accumulates each sample in the cycle it is taken and posts a snapshot
  // of (count, sum, sum of squares, saturated); the back end works out
  //   floor(isqrt(n*S2 - S1^2) / n)
  // from the snapshot. Since a snapshot carries the whole state, the two
  // halves never need to talk about anything else.

  logic       f_valid;
  logic       f_ready;
  rsd_stats_t f_data;
  logic       b_valid;
  logic       b_ready;
  rsd_stats_t b_data;

  // Front: sign-extend, square, accumulate; stops accumulating once the count is full
  // and flags the word as saturated.
  rsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data)
  );

  rsd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  // Back: n*S2 as two narrow partial products, S1^2, subtract, then a
  // digit-by-digit root and a restoring divide; result parked in an output
  // register so the next snapshot can be started while it waits.
  rsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (b_data),
    .results   (results)
  );

  // A saturated word can only come from a full count.
  a_sat_full: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.saturated |-> results.sample_count == CNT_OUT_W'(COUNT_MAX))
    else $error("saturated result without full count");

  // With fewer than two samples the deviation is zero.
  a_few_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.sample_count <= CNT_OUT_W'(1)) |-> results.std_dev == '0)
    else $error("nonzero deviation with fewer than two samples");

  // The deviation can never exceed half the sample range.
  a_std_bound: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.std_dev <= STD_MAX)
    else $error("deviation beyond sample range");

endmodule

`default_nettype wire
